// ===== hw/rtl/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg
// Shared types and constants for the region adjacency edge dedup block.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int LABEL_W         = 10;
  localparam int WSTART_W        = 10;
  localparam int WSIZE_W         = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 10;

  localparam int MAX_LABELS_DEF  = 1024;
  localparam int WINDOW_ROWS_DEF = 64;

  localparam logic                OP_PAIR  = 1'b0;
  localparam logic                OP_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WSTART = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WSIZE  = 2'd2;

  localparam logic                DEDUP_RST  = 1'b1;
  localparam logic [WSTART_W-1:0] WSTART_RST = 10'd1;
  localparam logic [WSIZE_W-1:0]  WSIZE_RST  = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ZERO,
    ST_CHECK,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/region_adjacency_edge_dedup.sv =====
// ----------------------------------------------------------------------------
// region_adjacency_edge_dedup
// Emits adjacency edges from label pairs, suppressing repeats with a seen
// bitmap held in one synchronous memory of 64-bit words.
// ----------------------------------------------------------------------------
// sequence: without dedup a request goes to emit; with dedup on a valid row
//   its bitmap word is read and checked, a duplicate dropped; on first touch
//   of a row each of its bitmap words (16 at default sizes) is zeroed, the new
//   bit marked, before emit, which waits while out_stall holds a result
// flow: one request at a time; only qualifying pair requests stall the input
// reset: control and row flags cleared, registers to defaults; bitmap undefined
// ----------------------------------------------------------------------------
module region_adjacency_edge_dedup #(
  parameter int MAX_LABELS  = rae_pkg::MAX_LABELS_DEF,
  parameter int WINDOW_ROWS = rae_pkg::WINDOW_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            opcode,
  input  logic [rae_pkg::LABEL_W-1:0]     center_label,
  input  logic [rae_pkg::LABEL_W-1:0]     neighbor_label,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rae_pkg::LABEL_W-1:0]     edge_low_label,
  output logic [rae_pkg::LABEL_W-1:0]     edge_high_label,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rae_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW        = $clog2(MAX_LABELS);
  localparam int WORD_LOG  = (CW > 6) ? 6 : CW - 1;
  localparam int WORD_W    = 1 << WORD_LOG;
  localparam int WSB       = CW - WORD_LOG;
  localparam int RB        = (WINDOW_ROWS > 1) ? $clog2(WINDOW_ROWS) : 1;
  localparam int AW        = RB + WSB;
  localparam int MEM_DEPTH = WINDOW_ROWS << WSB;
  localparam int EW        = 17;

  localparam logic [12:0]   ROWS_L = 13'(WINDOW_ROWS);
  localparam logic [EW-1:0] MAXL_L = EW'(MAX_LABELS);

  // configuration
  logic                           dedup_enable;
  logic [rae_pkg::WSTART_W-1:0]   window_start;
  logic [rae_pkg::WSIZE_W-1:0]    window_size;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dedup_enable <= rae_pkg::DEDUP_RST;
      window_start <= rae_pkg::WSTART_RST;
      window_size  <= rae_pkg::WSIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rae_pkg::CFG_DEDUP:  dedup_enable <= cfg_data[0];
        rae_pkg::CFG_WSTART: window_start <= cfg_data[rae_pkg::WSTART_W-1:0];
        rae_pkg::CFG_WSIZE:  window_size  <= cfg_data[rae_pkg::WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // pair qualification
  logic [EW-1:0]       center_ext, neigh_ext, ws_ext, row_full, col_full;
  logic [12:0]         size_eff;
  logic                qual;
  logic [RB-1:0]       row;
  logic [CW-1:0]       col;
  logic [WSB-1:0]      word_sel;
  logic [WORD_LOG-1:0] bit_sel;

  always_comb begin
    center_ext = EW'(center_label);
    neigh_ext  = EW'(neighbor_label);
    ws_ext     = EW'(window_start);
    size_eff   = (13'(window_size) > ROWS_L) ? ROWS_L : 13'(window_size);
    row_full   = center_ext - ws_ext;
    col_full   = neigh_ext - EW'(1);
    qual = (center_label != '0) && (center_ext >= ws_ext) &&
           (row_full < EW'(size_eff)) && (neighbor_label > center_label) &&
           (center_ext < MAXL_L) && (neigh_ext < MAXL_L);
    row      = row_full[RB-1:0];
    col      = col_full[CW-1:0];
    word_sel = col[CW-1:WORD_LOG];
    bit_sel  = col[WORD_LOG-1:0];
  end

  // control
  rae_pkg::state_t     state, state_next;
  logic [WINDOW_ROWS-1:0] row_valid;
  logic [RB-1:0]       row_q;
  logic [WSB-1:0]      word_q;
  logic [WORD_LOG-1:0] bit_q;
  logic [rae_pkg::LABEL_W-1:0] low_q, high_q;
  logic [WSB-1:0]      zero_cnt;
  logic [WORD_W-1:0]   rd_word, onehot;
  logic                in_accept, out_free;
  logic                mem_re, mem_we, set_valid, clr_all;
  logic [AW-1:0]       mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  assign in_stall  = (state != rae_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign onehot    = WORD_W'(1) << bit_q;

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {row_q, word_q};
    mem_wdata  = '0;
    set_valid  = 1'b0;
    clr_all    = 1'b0;
    unique case (state)
      rae_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == rae_pkg::OP_CLEAR) begin
            clr_all = 1'b1;
          end else if (qual) begin
            if (!dedup_enable) begin
              state_next = rae_pkg::ST_EMIT;
            end else if (row_valid[row]) begin
              mem_re     = 1'b1;
              state_next = rae_pkg::ST_CHECK;
            end else begin
              state_next = rae_pkg::ST_ZERO;
            end
          end
        end
      end
      rae_pkg::ST_ZERO: begin
        // zero the row, marking the wanted bit on the way
        mem_we    = 1'b1;
        mem_waddr = {row_q, zero_cnt};
        mem_wdata = (zero_cnt == word_q) ? onehot : '0;
        if (&zero_cnt) begin
          set_valid  = 1'b1;
          state_next = rae_pkg::ST_EMIT;
        end
      end
      rae_pkg::ST_CHECK: begin
        if (rd_word[bit_q]) begin
          state_next = rae_pkg::ST_IDLE;
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = rd_word | onehot;
          state_next = rae_pkg::ST_EMIT;
        end
      end
      rae_pkg::ST_EMIT: begin
        if (out_free) state_next = rae_pkg::ST_IDLE;
      end
      default: state_next = rae_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rae_pkg::ST_IDLE;
      row_valid <= '0;
      zero_cnt  <= '0;
    end else begin
      state <= state_next;
      if (clr_all) row_valid <= '0;
      else if (set_valid) row_valid[row_q] <= 1'b1;
      if (state == rae_pkg::ST_ZERO) zero_cnt <= zero_cnt + WSB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      row_q  <= row;
      word_q <= word_sel;
      bit_q  <= bit_sel;
      low_q  <= center_label;
      high_q <= neighbor_label;
    end
  end

  // seen bitmap
  logic [WORD_W-1:0] seen_mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) seen_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_word <= seen_mem[{row, word_sel}];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rae_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rae_pkg::ST_EMIT && out_free) begin
      edge_low_label  <= low_q;
      edge_high_label <= high_q;
    end
  end

endmodule

// ===== hw/rtl/rae_checker.sv =====
// ----------------------------------------------------------------------------
// rae_checker
// Port-level checks for the region adjacency edge dedup block.
// ----------------------------------------------------------------------------
module rae_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            opcode,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rae_pkg::LABEL_W-1:0]     edge_low_label,
  input logic [rae_pkg::LABEL_W-1:0]     edge_high_label
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(edge_low_label) &&
      $stable(edge_high_label))
    else $error("stalled result changed");

  // an edge always runs from a nonzero label to a larger one
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_low_label != '0) && (edge_low_label < edge_high_label))
    else $error("edge labels out of order");

  // an accepted clear request leaves the input unstalled in the following cycle
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == rae_pkg::OP_CLEAR) |=> !in_stall)
    else $error("clear request held the input");

  // every result follows an accepted pair request
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(in_stall))
    else $error("result without pending request");

endmodule

bind region_adjacency_edge_dedup rae_checker u_rae_checker (.*);

// ===== bench/region_adjacency_edge_dedup_tb.sv =====
// ----------------------------------------------------------------------------
// region_adjacency_edge_dedup_tb
// Self-checking bench for the adjacency edge dedup block. A queue-fed driver
// offers label pairs and clear requests, an in-bench model of the label window
// and seen bitmap predicts each new edge, and a monitor compares every emitted
// edge in order. Phases sweep dedup mode, window start and window size,
// including empty, oversized and zero-start windows, with random idle bursts
// on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module region_adjacency_edge_dedup_tb;

  typedef struct packed {
    logic                        op;
    logic [rae_pkg::LABEL_W-1:0] center;
    logic [rae_pkg::LABEL_W-1:0] neigh;
  } pair_req_t;

  typedef struct packed {
    logic [rae_pkg::LABEL_W-1:0] low;
    logic [rae_pkg::LABEL_W-1:0] high;
  } edge_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           opcode = rae_pkg::OP_PAIR;
  logic [rae_pkg::LABEL_W-1:0]    center_label = '0;
  logic [rae_pkg::LABEL_W-1:0]    neighbor_label = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rae_pkg::LABEL_W-1:0]    edge_low_label;
  logic [rae_pkg::LABEL_W-1:0]    edge_high_label;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rae_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rae_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pair_req_t pending_pairs[$];
  edge_t     expected_edges[$];

  logic                                dedup_on = rae_pkg::DEDUP_RST;
  logic [rae_pkg::WSTART_W-1:0]        win_start = rae_pkg::WSTART_RST;
  logic [rae_pkg::WSIZE_W-1:0]         win_size = rae_pkg::WSIZE_RST;
  logic [rae_pkg::WINDOW_ROWS_DEF-1:0] row_live = '0;
  bit [rae_pkg::MAX_LABELS_DEF-1:0]    seen_map [rae_pkg::WINDOW_ROWS_DEF];

  int   err_count = 0;
  logic in_taken = 1'b0;
  logic no_idle = 1'b0;
  logic press_go = 1'b0;
  logic hold_on = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;

  region_adjacency_edge_dedup dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .center_label    (center_label),
    .neighbor_label  (neighbor_label),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .edge_low_label  (edge_low_label),
    .edge_high_label (edge_high_label),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("edge check: %s", msg);
    err_count++;
  endtask

  function automatic void add_req(input pair_req_t r);
    pending_pairs = {pending_pairs, r};
  endfunction

  function automatic void predict_edge(input pair_req_t r);
    int eff;
    int row;
    edge_t e;
    if (r.op == rae_pkg::OP_CLEAR) begin
      row_live = '0;
      return;
    end
    eff = (win_size > rae_pkg::WINDOW_ROWS_DEF) ? rae_pkg::WINDOW_ROWS_DEF
                                                 : int'(win_size);
    if (r.center == 0 || r.center < win_start ||
        int'(r.center) >= int'(win_start) + eff) begin
      return;
    end
    if (r.neigh <= r.center) begin
      return;
    end
    if (int'(r.center) >= rae_pkg::MAX_LABELS_DEF ||
        int'(r.neigh) >= rae_pkg::MAX_LABELS_DEF) begin
      return;
    end
    if (dedup_on) begin
      row = int'(r.center) - int'(win_start);
      if (row >= rae_pkg::WINDOW_ROWS_DEF) begin
        return;
      end
      // first touch of a row since the last clear starts it empty
      if (!row_live[row]) begin
        seen_map[row] = '0;
        row_live[row] = 1'b1;
      end
      if (seen_map[row][r.neigh - 1]) begin
        return;
      end
      seen_map[row][r.neigh - 1] = 1'b1;
    end
    e.low = r.center;
    e.high = r.neigh;
    expected_edges = {expected_edges, e};
  endfunction

  function automatic pair_req_t make_pair();
    pair_req_t r;
    int eff;
    int pick;
    int c;
    int n;
    eff = (win_size > rae_pkg::WINDOW_ROWS_DEF) ? rae_pkg::WINDOW_ROWS_DEF
                                                 : int'(win_size);
    pick = $urandom_range(0, 99);
    r.op = rae_pkg::OP_PAIR;
    r.center = rae_pkg::LABEL_W'($urandom_range(0, 1023));
    r.neigh = rae_pkg::LABEL_W'($urandom_range(0, 1023));
    if (pick < 4) begin
      r.op = rae_pkg::OP_CLEAR;
    end else if (pick >= 14 && eff != 0 && win_start < 1023) begin
      // mostly centers inside the window, some just past its top
      if (pick < 22) begin
        c = int'(win_start) + eff + int'($urandom_range(0, 3));
      end else begin
        c = int'(win_start) + int'($urandom_range(0, eff - 1));
      end
      if (c > 1022) begin
        c = int'($urandom_range(win_start, 1022));
      end
      // close neighbors repeat often and exercise suppression
      if (pick < 65) begin
        n = c + int'($urandom_range(1, 6));
      end else begin
        n = c + int'($urandom_range(1, 1023 - c));
      end
      if (n > 1023) begin
        n = 1023;
      end
      r.center = rae_pkg::LABEL_W'(c);
      r.neigh = rae_pkg::LABEL_W'(n);
    end
    return r;
  endfunction

  task automatic write_reg(input logic [rae_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= rae_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      rae_pkg::CFG_DEDUP: dedup_on = val[0];
      rae_pkg::CFG_WSTART: win_start = rae_pkg::WSTART_W'(val);
      rae_pkg::CFG_WSIZE: win_size = rae_pkg::WSIZE_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(posedge clk);
    while (pending_pairs.size() != 0 || in_valid || expected_edges.size() != 0) begin
      @(posedge clk);
    end
    // duplicates and row zeroing may still be in flight with nothing expected
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(input int dd, input int st, input int sz, input int n,
                           input logic calm, input logic press);
    write_reg(rae_pkg::CFG_DEDUP, dd);
    write_reg(rae_pkg::CFG_WSTART, st);
    write_reg(rae_pkg::CFG_WSIZE, sz);
    @(posedge clk);
    no_idle = calm;
    press_go = press;
    repeat (n) add_req(make_pair());
    wait_quiet();
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        in_valid <= 1'b1;
        opcode <= pending_pairs[0].op;
        center_label <= pending_pairs[0].center;
        neighbor_label <= pending_pairs[0].neigh;
        pending_pairs.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_on) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long output hold-off while requests keep coming
  initial begin
    wait (press_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (300) @(posedge clk);
    hold_on = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        predict_edge(pair_req_t'{opcode, center_label, neighbor_label});
      end
      if (out_valid && !out_stall) begin
        if (expected_edges.size() == 0) begin
          report_mismatch($sformatf("unexpected edge %0d-%0d",
                                    edge_low_label, edge_high_label));
        end else begin
          if (edge_low_label !== expected_edges[0].low) begin
            report_mismatch($sformatf("edge_low_label %0d, want %0d",
                                      edge_low_label, expected_edges[0].low));
          end
          if (edge_high_label !== expected_edges[0].high) begin
            report_mismatch($sformatf("edge_high_label %0d, want %0d",
                                      edge_high_label, expected_edges[0].high));
          end
          expected_edges.delete(0);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("region_adjacency_edge_dedup verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset window covers centers 1 to 64 with dedup on
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd0, 10'd5});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1, 10'd2});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1, 10'd2});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1, 10'd1023});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd64, 10'd1023});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd65, 10'd100});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd10, 10'd10});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd10, 10'd3});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1023, 10'd1023});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1023, 10'd0});
    add_req(pair_req_t'{rae_pkg::OP_CLEAR, 10'd1023, 10'd1023});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1, 10'd2});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd1, 10'd2});
    add_req(pair_req_t'{rae_pkg::OP_CLEAR, 10'd0, 10'd0});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd64, 10'd1023});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd2, 10'd3});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd2, 10'd3});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd63, 10'd64});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd33, 10'd682});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd341, 10'd682});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd2, 10'd1022});
    add_req(pair_req_t'{rae_pkg::OP_PAIR, 10'd2, 10'd1022});
    wait_quiet();

    run_phase(1, 1, 64, 250, 1'b0, 1'b1);
    run_phase(0, 960, 64, 200, 1'b0, 1'b0);
    run_phase(1, 0, 1, 100, 1'b0, 1'b0);
    run_phase(1, 900, 127, 150, 1'b0, 1'b0);
    run_phase(1, 500, 0, 60, 1'b0, 1'b0);
    run_phase(0, 1023, 1, 40, 1'b0, 1'b0);
    run_phase(0, 1, 100, 120, 1'b0, 1'b0);
    run_phase(1, 300, 37, 200, 1'b1, 1'b0);

    if (err_count == 0) begin
      $display("region_adjacency_edge_dedup verification clean");
    end else begin
      $display("region_adjacency_edge_dedup verification failed");
    end
    $finish;
  end

endmodule
